>>> rtl/rfq_pkg.sv
package rfq_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Request codes
    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_REVERSE = 2'd2
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Storage access issued for one request
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_cmd_t;

    // Result of one request, minus the value read from storage
    typedef struct packed {
        status_t          status;
        logic             deq_ok;
        logic [CNT_W-1:0] count;
    } result_t;

    // (base + off) mod depth, with off never above depth
    function automatic logic [ADDR_W-1:0] slot_add(input logic [ADDR_W-1:0] base,
                                                   input logic [CNT_W-1:0]  off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
            sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    // Slot one step back, wrapping at zero
    function automatic logic [ADDR_W-1:0] slot_before(input logic [ADDR_W-1:0] base);
        return (base == '0) ? ADDR_W'(QUEUE_DEPTH - 1) : base - ADDR_W'(1);
    endfunction

endpackage

>>> rtl/rfq_ram.sv
module rfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read, holds while idle
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/rfq_ctrl.sv
module rfq_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  req_fire,
    input  logic [1:0]            req_op,
    output rfq_pkg::mem_cmd_t     mem_cmd,
    output rfq_pkg::result_t      result
);
    import rfq_pkg::*;

    logic [ADDR_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              rev_reg,   rev_next;

    // Pointer update and storage command for the current request
    always_comb begin
        front_next     = front_reg;
        count_next     = count_reg;
        rev_next       = rev_reg;
        mem_cmd        = '0;
        result.status  = ST_DONE;
        result.deq_ok  = 1'b0;

        unique case (req_op)
            OP_ENQUEUE: begin
                if (count_reg >= CNT_W'(QUEUE_DEPTH)) begin
                    result.status = ST_FULL;
                end else if (!rev_reg) begin
                    mem_cmd.wr_en   = 1'b1;
                    mem_cmd.wr_addr = slot_add(front_reg, count_reg);
                    count_next      = count_reg + CNT_W'(1);
                end else begin
                    front_next      = slot_before(front_reg);
                    mem_cmd.wr_en   = 1'b1;
                    mem_cmd.wr_addr = slot_before(front_reg);
                    count_next      = count_reg + CNT_W'(1);
                end
            end
            OP_DEQUEUE: begin
                if (count_reg == '0) begin
                    result.status = ST_EMPTY;
                end else begin
                    result.deq_ok = 1'b1;
                    mem_cmd.rd_en = 1'b1;
                    count_next    = count_reg - CNT_W'(1);
                    if (!rev_reg) begin
                        mem_cmd.rd_addr = front_reg;
                        front_next      = slot_add(front_reg, CNT_W'(1));
                    end else begin
                        mem_cmd.rd_addr = slot_add(front_reg, count_reg - CNT_W'(1));
                    end
                end
            end
            OP_REVERSE: begin
                rev_next = ~rev_reg;
            end
            default: begin
                // unused code: no operation
            end
        endcase

        // Nothing moves unless the beat is taken
        if (!req_fire) begin
            front_next    = front_reg;
            count_next    = count_reg;
            rev_next      = rev_reg;
            mem_cmd.wr_en = 1'b0;
            mem_cmd.rd_en = 1'b0;
        end
        result.count = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            count_reg <= '0;
            rev_reg   <= 1'b0;
        end else begin
            front_reg <= front_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
        end
    end

endmodule

>>> rtl/reversible_fifo_queue_unit.sv
// Bounded queue of signed 32-bit values, 16 entries, that can reverse its order
// in place. Each input beat carries one request (enqueue, dequeue or reverse) and
// produces exactly one result beat with a status, the dequeued value (zero for
// anything but a successful dequeue) and the fill count after the request. A
// request is taken every cycle while the result side keeps up; the result appears
// in the cycle after its request, set by the registered read of the entry
// storage, and waits in the result register while m_tready is low. Entries are
// never cleared, so the block is ready straight out of reset.
module reversible_fifo_queue_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] data_in
    input  logic [1:0]  s_tuser,   // [1:0] op
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] data_out, [36:32] fill_count, rest zero
    output logic [1:0]  m_tuser    // [1:0] status
);
    import rfq_pkg::*;

    logic              req_fire;
    mem_cmd_t          mem_cmd;
    result_t           result;
    logic [DATA_W-1:0] rd_data;

    result_t           res_reg;
    logic              res_valid_reg, res_valid_next;

    // A new beat is taken once the result register is free or emptying, never in reset
    assign s_tready = aresetn && (!res_valid_reg || m_tready);
    assign req_fire = s_tvalid && s_tready;

    rfq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req_fire (req_fire),
        .req_op   (s_tuser),
        .mem_cmd  (mem_cmd),
        .result   (result)
    );

    rfq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_cmd.wr_en),
        .wr_addr (mem_cmd.wr_addr),
        .wr_data (s_tdata[DATA_W-1:0]),
        .rd_en   (mem_cmd.rd_en),
        .rd_addr (mem_cmd.rd_addr),
        .rd_data (rd_data)
    );

    // Result register valid flag
    always_comb begin
        res_valid_next = res_valid_reg;
        if (req_fire) begin
            res_valid_next = 1'b1;
        end else if (m_tready) begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else begin
            res_valid_reg <= res_valid_next;
        end
    end

    // Result payload, read data joins from the RAM output register
    always_ff @(posedge aclk) begin
        if (req_fire) begin
            res_reg <= result;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tuser  = res_reg.status;
    assign m_tdata  = {3'b000, res_reg.count,
                       (res_reg.deq_ok ? rd_data : {DATA_W{1'b0}})};

endmodule

>>> tb/tb_reversible_fifo_queue_unit.sv
`timescale 1ns / 1ps

module tb_reversible_fifo_queue_unit;
    import rfq_pkg::*;

    // Selector value with no operation behind it
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // One result as the block should report it
    typedef struct packed {
        status_t           status;
        logic [DATA_W-1:0] value;
        logic [CNT_W-1:0]  count;
    } queue_answer_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    // Shadow copy of the queue
    logic [DATA_W-1:0] shadow_store [QUEUE_DEPTH];
    int unsigned       shadow_front;
    int unsigned       shadow_count;
    logic              shadow_reversed;

    queue_answer_t pending_answers [$];

    int error_count;
    int src_idle_pct;
    int sink_idle_pct;
    int stall_left;

    // Coverage tallies for the summary
    int n_enqueue, n_dequeue, n_reverse, n_unused;
    int n_full_drop, n_empty_deq, n_results, peak_fill, n_reversed_enq;

    reversible_fifo_queue_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Idle length: mostly short, now and then long
    function automatic int idle_length();
        if ($urandom_range(9) == 0) begin
            return int'($urandom_range(8, 25));
        end
        return int'($urandom_range(1, 3));
    endfunction

    function automatic int maybe_idle(input int pct);
        if (int'($urandom_range(99)) < pct) begin
            return idle_length();
        end
        return 0;
    endfunction

    // Apply one request to the shadow queue and return the answer it should give
    function automatic queue_answer_t predict_request(input logic [1:0] op,
                                                      input logic [DATA_W-1:0] data);
        queue_answer_t ans;
        ans.status = ST_DONE;
        ans.value  = '0;
        case (op)
            OP_ENQUEUE: begin
                n_enqueue++;
                if (shadow_count >= QUEUE_DEPTH) begin
                    ans.status = ST_FULL;
                    n_full_drop++;
                end else if (!shadow_reversed) begin
                    shadow_store[ADDR_W'((shadow_front + shadow_count) % QUEUE_DEPTH)] = data;
                    shadow_count++;
                end else begin
                    // reversed order: the logical back sits before the front slot
                    shadow_front = (shadow_front + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
                    shadow_store[ADDR_W'(shadow_front)] = data;
                    shadow_count++;
                    n_reversed_enq++;
                end
            end
            OP_DEQUEUE: begin
                n_dequeue++;
                if (shadow_count == 0) begin
                    ans.status = ST_EMPTY;
                    n_empty_deq++;
                end else if (!shadow_reversed) begin
                    ans.value    = shadow_store[ADDR_W'(shadow_front)];
                    shadow_front = (shadow_front + 1) % QUEUE_DEPTH;
                    shadow_count--;
                end else begin
                    ans.value = shadow_store[
                        ADDR_W'((shadow_front + shadow_count - 1) % QUEUE_DEPTH)];
                    shadow_count--;
                end
            end
            OP_REVERSE: begin
                n_reverse++;
                shadow_reversed = ~shadow_reversed;
            end
            default: begin
                n_unused++;
            end
        endcase
        ans.count = CNT_W'(shadow_count);
        if (int'(shadow_count) > peak_fill) peak_fill = int'(shadow_count);
        return ans;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("[%0t] MISMATCH %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
        error_count++;
    endtask

    // Send one request beat and record its expected answer once accepted
    task automatic send_request(input logic [1:0] op, input logic [DATA_W-1:0] data);
        int gap;
        gap = maybe_idle(src_idle_pct);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        pending_answers.push_back(predict_request(op, data));
    endtask

    // Result sink with random backpressure
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (int'($urandom_range(99)) < sink_idle_pct) begin
            m_tready   <= 1'b0;
            stall_left <= idle_length() - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Result checker
    always @(posedge aclk) begin
        queue_answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (pending_answers.size() == 0) begin
                report_mismatch("result beat with nothing pending", 64'd0, {24'd0, m_tdata});
            end else begin
                want = pending_answers.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", 64'(want.status), 64'(m_tuser));
                if (m_tdata[31:0] !== want.value)
                    report_mismatch("data_out", 64'(want.value), 64'(m_tdata[31:0]));
                if (m_tdata[36:32] !== want.count)
                    report_mismatch("fill_count", 64'(want.count), 64'(m_tdata[36:32]));
                if (m_tdata[39:37] !== 3'd0)
                    report_mismatch("tdata padding", 64'd0, 64'(m_tdata[39:37]));
            end
        end
    end

    // Empty-queue corner cases: dequeue, reverse and the unused selector
    task automatic test_empty_queue();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        send_request(OP_DEQUEUE, 32'hDEAD_BEEF);
        send_request(OP_REVERSE, 32'h0);
        send_request(OP_DEQUEUE, 32'h0);
        send_request(OP_REVERSE, 32'hFFFF_FFFF);
        send_request(OP_UNUSED, 32'h1234_5678);
    endtask

    // Value extremes, order reversal and enqueue while reversed
    task automatic test_extremes_and_reverse();
        src_idle_pct  = 30;
        sink_idle_pct = 30;
        send_request(OP_ENQUEUE, 32'h7FFF_FFFF);
        send_request(OP_ENQUEUE, 32'h8000_0000);
        send_request(OP_ENQUEUE, 32'hFFFF_FFFF);
        send_request(OP_ENQUEUE, 32'h0000_0000);
        send_request(OP_DEQUEUE, 32'h5555_5555);
        send_request(OP_REVERSE, 32'h0);
        send_request(OP_DEQUEUE, 32'h0);
        send_request(OP_ENQUEUE, 32'h0000_0001);
        send_request(OP_DEQUEUE, 32'h0);
        send_request(OP_REVERSE, 32'h0);
        send_request(OP_UNUSED, 32'hAAAA_AAAA);
    endtask

    // Fill to the limit, drop on full in both orders, then take a few back out
    task automatic test_full_queue();
        src_idle_pct  = 10;
        sink_idle_pct = 10;
        while (shadow_count < QUEUE_DEPTH) send_request(OP_ENQUEUE, $urandom);
        send_request(OP_ENQUEUE, 32'h8000_0000);
        send_request(OP_UNUSED, 32'h0);
        send_request(OP_REVERSE, 32'h0);
        send_request(OP_ENQUEUE, 32'h7FFF_FFFF);
        repeat (3) send_request(OP_DEQUEUE, 32'h0);
    endtask

    // Mixed traffic; fill bias and idle rates change every block of items
    task automatic test_random_traffic(input int total);
        int enq_pct;
        int r;
        logic [1:0]  op;
        logic [31:0] data;
        for (int i = 0; i < total; i++) begin
            if (i % 50 == 0) begin
                case ($urandom_range(2))
                    0: enq_pct = 75;
                    1: enq_pct = 50;
                    default: enq_pct = 25;
                endcase
                case ($urandom_range(3))
                    0: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
                    1: begin src_idle_pct = 20; sink_idle_pct = 0;  end
                    2: begin src_idle_pct = 0;  sink_idle_pct = 30; end
                    default: begin src_idle_pct = 40; sink_idle_pct = 40; end
                endcase
            end
            r = int'($urandom_range(99));
            if (r < 3) op = OP_UNUSED;
            else if (r < 13) op = OP_REVERSE;
            else if (int'($urandom_range(99)) < enq_pct) op = OP_ENQUEUE;
            else op = OP_DEQUEUE;
            case ($urandom_range(15))
                0: data = 32'h8000_0000;
                1: data = 32'h7FFF_FFFF;
                2: data = 32'hFFFF_FFFF;
                3: data = 32'h0000_0000;
                default: data = $urandom;
            endcase
            send_request(op, data);
        end
    endtask

    // Run limit
    initial begin
        #2_000_000;
        $display("reversible_fifo_queue_unit test failed");
        $finish;
    end

    initial begin
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tuser         = '0;
        m_tready        = 1'b0;
        stall_left      = 0;
        src_idle_pct    = 0;
        sink_idle_pct   = 0;
        error_count     = 0;
        shadow_front    = 0;
        shadow_count    = 0;
        shadow_reversed = 1'b0;
        n_enqueue = 0; n_dequeue = 0; n_reverse = 0; n_unused = 0;
        n_full_drop = 0; n_empty_deq = 0; n_results = 0; peak_fill = 0;
        n_reversed_enq = 0;
        foreach (shadow_store[i]) shadow_store[i] = '0;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_queue();
        test_extremes_and_reverse();
        test_full_queue();
        test_random_traffic(700);

        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Covered %0d enqueues (%0d while reversed, %0d dropped full), %0d dequeues",
                 n_enqueue, n_reversed_enq, n_full_drop, n_dequeue);
        $display("  (%0d on empty), %0d reversals, %0d no-ops; %0d results, peak fill %0d",
                 n_empty_deq, n_reverse, n_unused, n_results, peak_fill);
        if (error_count == 0) begin
            $display("reversible_fifo_queue_unit test passed");
        end else begin
            $display("reversible_fifo_queue_unit test failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/rfq_pkg.sv
rtl/rfq_ram.sv
rtl/rfq_ctrl.sv
rtl/reversible_fifo_queue_unit.sv
tb/tb_reversible_fifo_queue_unit.sv
